[rtl/core/vector3_alu_defines.svh]
// assertion macros shared by the vector unit
`ifndef VECTOR3_ALU_DEFINES_SVH
`define VECTOR3_ALU_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define V3A_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define V3A_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/v3a_pkg.sv]
package v3a_pkg;

    typedef enum logic [1:0] {
        ACT_DOT   = 2'd0,
        ACT_CROSS = 2'd1,
        ACT_LEN   = 2'd2,
        ACT_NORM  = 2'd3
    } action_t;

    localparam int OUT_BITS     = 33;
    localparam int QUO_BITS     = 15;
    localparam int UNIT_SHIFT   = 14;
    localparam int M_TDATA_BITS = ((4 * OUT_BITS + 7) / 8) * 8;

    localparam logic [QUO_BITS-1:0] UNIT_ONE_Q14 = 15'd16384;

endpackage

[rtl/core/v3a_sqrt_cell.sv]
module v3a_sqrt_cell #(
    parameter int NW = 34,
    parameter int RW = 17,
    parameter int PW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_n,
    input  logic [RW:0]   in_rem,
    input  logic [RW-1:0] in_root,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [NW-1:0] out_n,
    output logic [RW:0]   out_rem,
    output logic [RW-1:0] out_root,
    output logic [PW-1:0] out_pay
);

    logic          valid_reg;
    logic [NW-1:0] n_reg;
    logic [RW:0]   rem_reg;
    logic [RW-1:0] root_reg;
    logic [PW-1:0] pay_reg;

    logic [RW+2:0] trial_rem;
    logic [RW+2:0] trial_sub;
    logic [RW+2:0] diff;
    logic          fits;
    logic [RW:0]   rem_next;
    logic [RW-1:0] root_next;
    logic [NW-1:0] n_next;

    // bring down the next two radicand bits and try root*4+1
    always_comb begin
        trial_rem = {in_rem, in_n[NW-1 -: 2]};
        trial_sub = {1'b0, in_root, 2'b01};
        diff      = trial_rem - trial_sub;
        fits      = (trial_rem >= trial_sub);
        rem_next  = fits ? diff[RW:0] : trial_rem[RW:0];
        root_next = {in_root[RW-2:0], fits};
        n_next    = {in_n[NW-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg    <= n_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_n     = n_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_pay   = pay_reg;

endmodule

[rtl/core/v3a_div_cell.sv]
module v3a_div_cell #(
    parameter int DW    = 17,
    parameter int RMW   = 31,
    parameter int QW    = 15,
    parameter int SHIFT = 14,
    parameter int PW    = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [DW-1:0]  in_len,
    input  logic [RMW-1:0] in_rem [3],
    input  logic [QW-1:0]  in_quo [3],
    input  logic [PW-1:0]  in_pay,
    output logic           out_valid,
    output logic [DW-1:0]  out_len,
    output logic [RMW-1:0] out_rem [3],
    output logic [QW-1:0]  out_quo [3],
    output logic [PW-1:0]  out_pay
);

    logic           valid_reg;
    logic [DW-1:0]  len_reg;
    logic [RMW-1:0] rem_reg [3];
    logic [QW-1:0]  quo_reg [3];
    logic [PW-1:0]  pay_reg;

    logic [RMW-1:0] dvs;
    logic [RMW-1:0] rem_next [3];
    logic [QW-1:0]  quo_next [3];

    // one quotient bit per cell, same divisor for all three lanes
    always_comb begin
        dvs = {{(RMW-DW){1'b0}}, in_len} << SHIFT;
        for (int i = 0; i < 3; i++) begin
            if (in_rem[i] >= dvs) begin
                rem_next[i] = in_rem[i] - dvs;
                quo_next[i] = in_quo[i] | (QW'(1) << SHIFT);
            end else begin
                rem_next[i] = in_rem[i];
                quo_next[i] = in_quo[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg <= in_len;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_len   = len_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_pay   = pay_reg;

endmodule

[rtl/core/vector3_alu.sv]
// path from input beat to output beat: multiplier stage, sum stage, square root row, divide row, output register
// throughput: one beat per cycle; the whole row of cells advances together and
// stalls only while the output register holds a beat that m_tready does not take
// the depth is set by one root bit per square root cell and one quotient bit per divide cell
// reset clears the valid bit of every stage and the output register; data is not cleared
`include "vector3_alu_defines.svh"

module vector3_alu #(
    parameter int COMPONENT_BITS = 16,
    localparam int S_TDATA_BITS  = ((6 * COMPONENT_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, zero pad
    input  logic [S_TDATA_BITS-1:0]             s_tdata,
    // action
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // scalar_out, vec_x, vec_y, vec_z, zero pad
    output logic [v3a_pkg::M_TDATA_BITS-1:0]    m_tdata,
    // zero_vector
    output logic                                m_tuser
);

    localparam int CB   = COMPONENT_BITS;
    localparam int PRB  = 2 * CB;
    localparam int SW   = 2 * CB + 2;
    localparam int CW   = 2 * CB + 1;
    localparam int RW   = CB + 1;
    localparam int RMW  = CB + 1 + v3a_pkg::UNIT_SHIFT;
    localparam int QW   = v3a_pkg::QUO_BITS;
    localparam int OB   = v3a_pkg::OUT_BITS;
    localparam int SQPW = 3 + SW + 3 * CW + 3 * CB;
    localparam int DVPW = 3 + SW + 3 * CW + 3;
    localparam int PADB = v3a_pkg::M_TDATA_BITS - 4 * OB;

    logic en;

    // ---------------- input unpack and multiplier stage
    logic signed [CB-1:0] ax, ay, az, bx, by, bz;
    v3a_pkg::action_t     act_in;
    logic signed [CB-1:0] op_a [6];
    logic signed [CB-1:0] op_b [6];
    logic signed [PRB-1:0] p_next [6];

    assign ax     = s_tdata[CB-1:0];
    assign ay     = s_tdata[2*CB-1:CB];
    assign az     = s_tdata[3*CB-1:2*CB];
    assign bx     = s_tdata[4*CB-1:3*CB];
    assign by     = s_tdata[5*CB-1:4*CB];
    assign bz     = s_tdata[6*CB-1:5*CB];
    assign act_in = v3a_pkg::action_t'(s_tuser);

    // first three multipliers are shared by dot, cross and sum of squares
    always_comb begin
        unique case (act_in) inside
            v3a_pkg::ACT_DOT: begin
                op_a[0] = ax; op_b[0] = bx;
                op_a[1] = ay; op_b[1] = by;
                op_a[2] = az; op_b[2] = bz;
            end
            v3a_pkg::ACT_CROSS: begin
                op_a[0] = ay; op_b[0] = bz;
                op_a[1] = az; op_b[1] = by;
                op_a[2] = az; op_b[2] = bx;
            end
            v3a_pkg::ACT_LEN, v3a_pkg::ACT_NORM: begin
                op_a[0] = ax; op_b[0] = ax;
                op_a[1] = ay; op_b[1] = ay;
                op_a[2] = az; op_b[2] = az;
            end
        endcase
        op_a[3] = ax; op_b[3] = bz;
        op_a[4] = ax; op_b[4] = by;
        op_a[5] = ay; op_b[5] = bx;
        for (int i = 0; i < 6; i++) begin
            p_next[i] = PRB'(op_a[i]) * PRB'(op_b[i]);
        end
    end

    logic                  va_reg;
    v3a_pkg::action_t      act_a_reg;
    logic                  zero_a_reg;
    logic signed [CB-1:0]  ax_a_reg, ay_a_reg, az_a_reg;
    logic signed [PRB-1:0] p_reg [6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act_a_reg  <= act_in;
            zero_a_reg <= (ax == '0) && (ay == '0) && (az == '0);
            ax_a_reg   <= ax;
            ay_a_reg   <= ay;
            az_a_reg   <= az;
            p_reg      <= p_next;
        end
    end

    // ---------------- sum stage
    logic                 vb_reg;
    v3a_pkg::action_t     act_b_reg;
    logic                 zero_b_reg;
    logic signed [CB-1:0] ax_b_reg, ay_b_reg, az_b_reg;
    logic signed [SW-1:0] s_b_reg;
    logic signed [CW-1:0] cx_b_reg, cy_b_reg, cz_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act_b_reg  <= act_a_reg;
            zero_b_reg <= zero_a_reg;
            ax_b_reg   <= ax_a_reg;
            ay_b_reg   <= ay_a_reg;
            az_b_reg   <= az_a_reg;
            s_b_reg    <= SW'(p_reg[0]) + SW'(p_reg[1]) + SW'(p_reg[2]);
            cx_b_reg   <= CW'(p_reg[0]) - CW'(p_reg[1]);
            cy_b_reg   <= CW'(p_reg[2]) - CW'(p_reg[3]);
            cz_b_reg   <= CW'(p_reg[4]) - CW'(p_reg[5]);
        end
    end

    // ---------------- square root row, one root bit per cell
    logic            sq_valid [RW+1];
    logic [SW-1:0]   sq_n     [RW+1];
    logic [RW:0]     sq_rem   [RW+1];
    logic [RW-1:0]   sq_root  [RW+1];
    logic [SQPW-1:0] sq_pay   [RW+1];

    assign sq_valid[0] = vb_reg;
    assign sq_n[0]     = s_b_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_pay[0]   = {act_b_reg, zero_b_reg, s_b_reg, cx_b_reg, cy_b_reg, cz_b_reg,
                          ax_b_reg, ay_b_reg, az_b_reg};

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        v3a_sqrt_cell #(
            .NW (SW),
            .RW (RW),
            .PW (SQPW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid[k]),
            .in_n      (sq_n[k]),
            .in_rem    (sq_rem[k]),
            .in_root   (sq_root[k]),
            .in_pay    (sq_pay[k]),
            .out_valid (sq_valid[k+1]),
            .out_n     (sq_n[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_root  (sq_root[k+1]),
            .out_pay   (sq_pay[k+1])
        );
    end

    logic [1:0]           sq_act;
    logic                 sq_zero;
    logic signed [SW-1:0] sq_s;
    logic signed [CW-1:0] sq_cx, sq_cy, sq_cz;
    logic signed [CB-1:0] sq_ax, sq_ay, sq_az;
    logic [RW-1:0]        sq_len;
    logic [CB-1:0]        mag_x, mag_y, mag_z;

    assign {sq_act, sq_zero, sq_s, sq_cx, sq_cy, sq_cz, sq_ax, sq_ay, sq_az} = sq_pay[RW];
    assign sq_len = sq_root[RW];
    assign mag_x  = sq_ax[CB-1] ? CB'(-sq_ax) : sq_ax;
    assign mag_y  = sq_ay[CB-1] ? CB'(-sq_ay) : sq_ay;
    assign mag_z  = sq_az[CB-1] ? CB'(-sq_az) : sq_az;

    // ---------------- divide row, one quotient bit per cell
    logic            dv_valid [QW+1];
    logic [RW-1:0]   dv_len   [QW+1];
    logic [RMW-1:0]  dv_rem   [QW+1][3];
    logic [QW-1:0]   dv_quo   [QW+1][3];
    logic [DVPW-1:0] dv_pay   [QW+1];

    // numerator is the magnitude in Q17.14 scale (CB+1 integer bits, UNIT_SHIFT fraction bits)
    assign dv_valid[0]  = sq_valid[RW];
    assign dv_len[0]    = sq_len;
    assign dv_rem[0][0] = {1'b0, mag_x, {v3a_pkg::UNIT_SHIFT{1'b0}}};
    assign dv_rem[0][1] = {1'b0, mag_y, {v3a_pkg::UNIT_SHIFT{1'b0}}};
    assign dv_rem[0][2] = {1'b0, mag_z, {v3a_pkg::UNIT_SHIFT{1'b0}}};
    assign dv_quo[0][0] = '0;
    assign dv_quo[0][1] = '0;
    assign dv_quo[0][2] = '0;
    assign dv_pay[0]    = {sq_act, sq_zero, sq_s, sq_cx, sq_cy, sq_cz,
                           sq_ax[CB-1], sq_ay[CB-1], sq_az[CB-1]};

    for (genvar k = 0; k < QW; k++) begin : g_div
        v3a_div_cell #(
            .DW    (RW),
            .RMW   (RMW),
            .QW    (QW),
            .SHIFT (QW - 1 - k),
            .PW    (DVPW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_valid[k]),
            .in_len    (dv_len[k]),
            .in_rem    (dv_rem[k]),
            .in_quo    (dv_quo[k]),
            .in_pay    (dv_pay[k]),
            .out_valid (dv_valid[k+1]),
            .out_len   (dv_len[k+1]),
            .out_rem   (dv_rem[k+1]),
            .out_quo   (dv_quo[k+1]),
            .out_pay   (dv_pay[k+1])
        );
    end

    logic [1:0]           dv_act_raw;
    v3a_pkg::action_t     dv_act;
    logic                 dv_zero;
    logic signed [SW-1:0] dv_s;
    logic signed [CW-1:0] dv_cx, dv_cy, dv_cz;
    logic                 dv_sx, dv_sy, dv_sz;
    logic [QW-1:0]        q_x, q_y, q_z;

    assign {dv_act_raw, dv_zero, dv_s, dv_cx, dv_cy, dv_cz, dv_sx, dv_sy, dv_sz} = dv_pay[QW];
    assign dv_act = v3a_pkg::action_t'(dv_act_raw);
    assign q_x    = dv_quo[QW][0];
    assign q_y    = dv_quo[QW][1];
    assign q_z    = dv_quo[QW][2];

    // ---------------- result select and output register
    logic [OB-1:0] scalar_next, vx_next, vy_next, vz_next;
    logic [OB-1:0] nx, ny, nz;

    always_comb begin
        nx = dv_sx ? -OB'(q_x) : OB'(q_x);
        ny = dv_sy ? -OB'(q_y) : OB'(q_y);
        nz = dv_sz ? -OB'(q_z) : OB'(q_z);
        scalar_next = '0;
        vx_next     = '0;
        vy_next     = '0;
        vz_next     = '0;
        unique case (dv_act) inside
            v3a_pkg::ACT_DOT: begin
                scalar_next = OB'(dv_s);
            end
            v3a_pkg::ACT_CROSS: begin
                vx_next = OB'(dv_cx);
                vy_next = OB'(dv_cy);
                vz_next = OB'(dv_cz);
            end
            v3a_pkg::ACT_LEN: begin
                scalar_next = OB'(dv_len[QW]);
            end
            v3a_pkg::ACT_NORM: begin
                // zero length leaves the vector at zero
                if (!dv_zero) begin
                    vx_next = nx;
                    vy_next = ny;
                    vz_next = nz;
                end
            end
        endcase
    end

    logic                              m_tvalid_reg;
    logic [v3a_pkg::M_TDATA_BITS-1:0]  m_tdata_reg;
    logic                              m_tuser_reg;

    assign en = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_valid[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {{PADB{1'b0}}, vz_next, vy_next, vx_next, scalar_next};
            m_tuser_reg <= dv_zero;
        end
    end

    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- checks
    `V3A_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, va_reg, "accepted beat lost at entry")
    `V3A_ASSERT_IMP(a_zero_len, sq_valid[RW] && (sq_act == v3a_pkg::ACT_LEN || sq_act == v3a_pkg::ACT_NORM), (sq_len == '0) == sq_zero, "length zero disagrees with zero flag")
    `V3A_ASSERT_IMP(a_norm_range, dv_valid[QW] && dv_act == v3a_pkg::ACT_NORM && !dv_zero, q_x <= v3a_pkg::UNIT_ONE_Q14 && q_y <= v3a_pkg::UNIT_ONE_Q14 && q_z <= v3a_pkg::UNIT_ONE_Q14, "normalized component above one")
    `V3A_ASSERT_IMP(a_zero_out, m_tvalid && m_tuser, m_tdata == '0, "zero vector gave nonzero result")

endmodule
